// File: sv/sellmeier_refractive_index_assert.svh
// Assertion macros for the checker of the Sellmeier index block.
`ifndef SELLMEIER_REFRACTIVE_INDEX_ASSERT_SVH
`define SELLMEIER_REFRACTIVE_INDEX_ASSERT_SVH

// Same-cycle implication, ignored while reset is applied.
`define SRI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked during reset as well.
`define SRI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/sri_pkg.sv
// Shared types, widths and constants of the Sellmeier refractive index block.
package sri_pkg;

  // Field widths.
  localparam int WL_W      = 21;
  localparam int STR_W     = 26;
  localparam int EN_W      = 24;
  localparam int IDX_W     = 18;
  localparam int SLOPE_W   = 41;
  localparam int STAT_W    = 2;
  localparam int CFG_W     = 26;
  localparam int CFG_IDX_W = 2;

  // Internal widths.
  localparam int KQ_W = 35;  // 2*pi*hbarc constant, Q8.16 times Q12.8
  localparam int SQ_W = 48;  // squared energies, Q16.32
  localparam int QV_W = 62;  // capped quotients
  localparam int RT_W = 32;  // square root result
  localparam int RW_W = 52;  // root times wavelength

  // 2*pi*hbarc scaled by 2^24.
  localparam logic [KQ_W-1:0] KQ = 35'd20801094641;

  // Quotient caps.
  localparam logic [63:0] QUOT_CAP = 64'h2000_0000_0000_0000;
  localparam logic [63:0] E_CAP    = 64'h0000_0000_0100_0000;

  // Default divider shape.
  localparam int DIV_A_W   = STR_W;
  localparam int DIV_SHIFT = 48;
  localparam int DIV_B_W   = SQ_W;
  localparam int DIV_Q_W   = QV_W;

  // Output constants.
  localparam logic [IDX_W-1:0]   DEFAULT_INDEX = 18'd95224;
  localparam logic [IDX_W-1:0]   INDEX_MAX     = 18'h3FFFF;
  localparam logic [SLOPE_W-1:0] SLOPE_CAP     = 41'h100_0000_0000;

  // Register reset values.
  localparam logic [STR_W-1:0] STRENGTH_ONE_RST = 26'd1846704;
  localparam logic [EN_W-1:0]  ENERGY_ONE_RST   = 24'd673767;
  localparam logic [STR_W-1:0] STRENGTH_TWO_RST = 26'd13599323;
  localparam logic [EN_W-1:0]  ENERGY_TWO_RST   = 24'd1033950;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_STRENGTH_ONE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENERGY_ONE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STRENGTH_TWO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ENERGY_TWO   = 2'd3;

  // Status codes.
  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_DEFAULT = 2'd1;
  localparam logic [STAT_W-1:0] STAT_ERROR   = 2'd2;

  // Context of one word as it moves down the pipeline.
  typedef struct packed {
    logic [WL_W-1:0]  wl;
    logic             neg;
    logic             bad;
    logic [SQ_W-1:0]  e2;
    logic [SQ_W-1:0]  d1;
    logic [SQ_W-1:0]  d2mag;
    logic             d2neg;
    logic [QV_W-1:0]  t1;
    logic [QV_W-1:0]  t2;
    logic [63:0]      s;
    logic [QV_W:0]    u;
    logic [RT_W-1:0]  root;
    logic [IDX_W-1:0] idx;
  } sri_item_t;

endpackage

// File: sv/sellmeier_refractive_index.sv
// Two-term Sellmeier refractive index and its wavelength slope, fully pipelined.
// Its pipeline holds the divider chain (three 62-bit quotient pipelines in series plus
// a 24-bit one) and the 32-stage square root.
// Throughput: one word per clock cycle; busy stays low and results cannot be held off.
// Reset clears every valid bit and restores the register defaults; words in flight are lost.
module sellmeier_refractive_index (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [sri_pkg::WL_W-1:0] in_wavelength,
  input  logic                          cfg_we,
  input  logic [sri_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [sri_pkg::CFG_W-1:0]     cfg_data,
  output logic                          out_valid,
  output logic [sri_pkg::IDX_W-1:0]     out_index,
  output logic signed [sri_pkg::SLOPE_W-1:0] out_index_slope,
  output logic [sri_pkg::STAT_W-1:0]    out_status
);

  import sri_pkg::*;

  localparam int ITEM_W = $bits(sri_item_t);
  localparam int BL_W   = 31;
  localparam int AL_W   = 24;
  localparam int PP_W   = AL_W + BL_W;
  localparam int PS_W   = PP_W + BL_W;
  localparam int PF_W   = 110;
  localparam int MF_W   = PF_W - 32;
  localparam int SR_W   = 66;

  // Configuration registers and the squared resonance energies.
  logic [STR_W-1:0] str1_r, str2_r;
  logic [EN_W-1:0]  en1_r, en2_r;
  logic [SQ_W-1:0]  e1sq_r, e2sq_r;

  logic accept;

  logic       p0_vld_r;
  sri_item_t  p0_r, p0_nxt;

  logic              de_vld;
  logic [EN_W:0]     de_q;
  logic [ITEM_W-1:0] de_tag;

  logic      p1_vld_r, p2_vld_r, p3_vld_r;
  sri_item_t p1_r, p1_nxt, p2_r, p2_nxt, p3_r, p3_nxt;

  logic              dt1_vld, dt2_vld, du1_vld, du2_vld, dg_vld;
  logic [QV_W:0]     dt1_q, dt2_q, du1_q, du2_q, dg_q;
  logic [ITEM_W-1:0] dt1_tag, du1_tag, dg_tag;
  logic              dt2_tag, du2_tag;

  logic             sq_vld_r  [0:RT_W];
  logic [63:0]      sq_rem_r  [0:RT_W];
  logic [RT_W-1:0]  sq_root_r [0:RT_W];
  sri_item_t        sq_ctx_r  [0:RT_W];
  sri_item_t        sq0_nxt;

  logic            rd_vld_r;
  sri_item_t       rd_r, rd_nxt;
  logic [RT_W-1:0] rd_root;

  logic            p6_vld_r;
  sri_item_t       p6_r;
  logic [RW_W-1:0] p6_rw_r;

  logic            p7_vld_r;
  sri_item_t       p7_r;
  logic [QV_W-1:0] g_r;

  logic            m1_vld_r, m2_vld_r, m3_vld_r;
  sri_item_t       m1_r, m2_r, m3_r;
  logic [PP_W-1:0] pll_r, plh_r, phl_r, phh_r;
  logic [PS_W-1:0] x_r, y_r;
  logic [PF_W-1:0] p_r;

  logic [MF_W-1:0]    m_full;
  logic [SLOPE_W-1:0] m_cap;

  logic               out_valid_r;
  logic [IDX_W-1:0]   out_index_r;
  logic [SLOPE_W-1:0] out_slope_r;
  logic [STAT_W-1:0]  out_status_r;

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      str1_r <= STRENGTH_ONE_RST;
      en1_r  <= ENERGY_ONE_RST;
      str2_r <= STRENGTH_TWO_RST;
      en2_r  <= ENERGY_TWO_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_STRENGTH_ONE: str1_r <= cfg_data[STR_W-1:0];
        REG_ENERGY_ONE:   en1_r  <= cfg_data[EN_W-1:0];
        REG_STRENGTH_TWO: str2_r <= cfg_data[STR_W-1:0];
        REG_ENERGY_TWO:   en2_r  <= cfg_data[EN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    e1sq_r <= SQ_W'(en1_r) * SQ_W'(en1_r);
    e2sq_r <= SQ_W'(en2_r) * SQ_W'(en2_r);
  end

  // Input word capture; the pipeline never stalls.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    p0_nxt     = '0;
    p0_nxt.wl  = in_wavelength;
    p0_nxt.neg = in_wavelength[WL_W-1];
    p0_nxt.bad = (in_wavelength == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_vld_r <= 1'b0;
    end else begin
      p0_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    p0_r <= p0_nxt;
  end

  // Photon energy e = round(KQ / wavelength), capped at 2^24.
  sri_div #(
    .A_W(KQ_W), .SHIFT(0), .B_W(WL_W-1), .Q_W(EN_W), .CAP(E_CAP), .TAG_W(ITEM_W)
  ) u_div_e (
    .clk(clk), .rst_n(rst_n), .in_vld(p0_vld_r), .in_a(KQ), .in_b(p0_r.wl[WL_W-2:0]),
    .in_tag(p0_r), .out_vld(de_vld), .out_q(de_q), .out_tag(de_tag)
  );

  // Short wavelength check and e squared.
  always_comb begin
    p1_nxt     = de_tag;
    p1_nxt.bad = p1_nxt.bad | (de_q >= {1'b0, en1_r});
    p1_nxt.e2  = SQ_W'(de_q[EN_W-1:0]) * SQ_W'(de_q[EN_W-1:0]);
  end

  // Both denominators.
  always_comb begin
    p2_nxt    = p1_r;
    p2_nxt.d1 = e1sq_r - p1_r.e2;
    if (e2sq_r >= p1_r.e2) begin
      p2_nxt.d2mag = e2sq_r - p1_r.e2;
      p2_nxt.d2neg = 1'b0;
    end else begin
      p2_nxt.d2mag = p1_r.e2 - e2sq_r;
      p2_nxt.d2neg = 1'b1;
    end
    p2_nxt.bad = p2_nxt.bad | (p2_nxt.d2mag == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
    end else begin
      p1_vld_r <= de_vld;
      p2_vld_r <= p1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    p1_r <= p1_nxt;
    p2_r <= p2_nxt;
  end

  // Oscillator terms t1 and t2.
  sri_div #(
    .A_W(STR_W), .SHIFT(48), .B_W(SQ_W), .Q_W(QV_W), .CAP(QUOT_CAP), .TAG_W(ITEM_W)
  ) u_div_t1 (
    .clk(clk), .rst_n(rst_n), .in_vld(p2_vld_r), .in_a(str1_r), .in_b(p2_r.d1),
    .in_tag(p2_r), .out_vld(dt1_vld), .out_q(dt1_q), .out_tag(dt1_tag)
  );

  sri_div #(
    .A_W(STR_W), .SHIFT(48), .B_W(SQ_W), .Q_W(QV_W), .CAP(QUOT_CAP), .TAG_W(1)
  ) u_div_t2 (
    .clk(clk), .rst_n(rst_n), .in_vld(p2_vld_r), .in_a(str2_r), .in_b(p2_r.d2mag),
    .in_tag(p2_r.bad), .out_vld(dt2_vld), .out_q(dt2_q), .out_tag(dt2_tag)
  );

  // Squared index s = 1 + t1 +/- t2 in Q.32.
  always_comb begin
    logic [63:0] s_base;
    p3_nxt    = dt1_tag;
    p3_nxt.t1 = dt1_q[QV_W-1:0];
    p3_nxt.t2 = dt2_q[QV_W-1:0];
    s_base    = (64'd1 << 32) + 64'(p3_nxt.t1);
    p3_nxt.s  = p3_nxt.d2neg ? (s_base - 64'(p3_nxt.t2)) : (s_base + 64'(p3_nxt.t2));
    p3_nxt.bad = p3_nxt.bad | dt2_tag | p3_nxt.s[63] | (p3_nxt.s == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_vld_r <= 1'b0;
    end else begin
      p3_vld_r <= dt1_vld && dt2_vld;
    end
  end

  always_ff @(posedge clk) begin
    p3_r <= p3_nxt;
  end

  // Slope sum terms t1/d1 and t2/d2.
  sri_div #(
    .A_W(QV_W), .SHIFT(32), .B_W(SQ_W), .Q_W(QV_W), .CAP(QUOT_CAP), .TAG_W(ITEM_W)
  ) u_div_u1 (
    .clk(clk), .rst_n(rst_n), .in_vld(p3_vld_r), .in_a(p3_r.t1), .in_b(p3_r.d1),
    .in_tag(p3_r), .out_vld(du1_vld), .out_q(du1_q), .out_tag(du1_tag)
  );

  sri_div #(
    .A_W(QV_W), .SHIFT(32), .B_W(SQ_W), .Q_W(QV_W), .CAP(QUOT_CAP), .TAG_W(1)
  ) u_div_u2 (
    .clk(clk), .rst_n(rst_n), .in_vld(p3_vld_r), .in_a(p3_r.t2), .in_b(p3_r.d2mag),
    .in_tag(p3_r.bad), .out_vld(du2_vld), .out_q(du2_q), .out_tag(du2_tag)
  );

  always_comb begin
    sq0_nxt     = du1_tag;
    sq0_nxt.u   = {1'b0, du1_q[QV_W-1:0]} + {1'b0, du2_q[QV_W-1:0]};
    sq0_nxt.bad = sq0_nxt.bad | du2_tag;
  end

  // Square root load stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r[0] <= 1'b0;
    end else begin
      sq_vld_r[0] <= du1_vld && du2_vld;
    end
  end

  always_ff @(posedge clk) begin
    sq_rem_r[0]  <= sq0_nxt.s;
    sq_root_r[0] <= '0;
    sq_ctx_r[0]  <= sq0_nxt;
  end

  // Digit-by-digit square root, one root bit per stage, most significant first.
  for (genvar j = 1; j <= RT_W; j++) begin : g_sqrt
    localparam int K = RT_W - j;
    logic [SR_W-1:0] sub;
    logic [SR_W-1:0] rem_x;
    logic            take;

    assign sub   = (SR_W'(sq_root_r[j-1]) << (K + 1)) + (SR_W'(1) << (2 * K));
    assign rem_x = SR_W'(sq_rem_r[j-1]);
    assign take  = rem_x >= sub;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_vld_r[j] <= 1'b0;
      end else begin
        sq_vld_r[j] <= sq_vld_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      sq_rem_r[j]  <= take ? 64'(rem_x - sub) : sq_rem_r[j-1];
      sq_root_r[j] <= sq_root_r[j-1] | (RT_W'(take) << K);
      sq_ctx_r[j]  <= sq_ctx_r[j-1];
    end
  end

  // Round the root to nearest and saturate the index.
  assign rd_root = sq_root_r[RT_W] + RT_W'(sq_rem_r[RT_W] > 64'(sq_root_r[RT_W]));

  always_comb begin
    rd_nxt      = sq_ctx_r[RT_W];
    rd_nxt.root = rd_root;
    rd_nxt.idx  = (rd_root > RT_W'(INDEX_MAX)) ? INDEX_MAX : rd_root[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      p6_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= sq_vld_r[RT_W];
      p6_vld_r <= rd_vld_r;
    end
  end

  // Root times wavelength for the slope divisor.
  always_ff @(posedge clk) begin
    rd_r    <= rd_nxt;
    p6_r    <= rd_r;
    p6_rw_r <= RW_W'(rd_r.root) * RW_W'(rd_r.wl[WL_W-2:0]);
  end

  // g = round(u * 2^24 / (r * w)).
  sri_div #(
    .A_W(QV_W+1), .SHIFT(24), .B_W(RW_W), .Q_W(QV_W), .CAP(QUOT_CAP), .TAG_W(ITEM_W)
  ) u_div_g (
    .clk(clk), .rst_n(rst_n), .in_vld(p6_vld_r), .in_a(p6_r.u), .in_b(p6_rw_r),
    .in_tag(p6_r), .out_vld(dg_vld), .out_q(dg_q), .out_tag(dg_tag)
  );

  // e^2 * g in partial products, then summed over two stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p7_vld_r <= 1'b0;
      m1_vld_r <= 1'b0;
      m2_vld_r <= 1'b0;
      m3_vld_r <= 1'b0;
    end else begin
      p7_vld_r <= dg_vld;
      m1_vld_r <= p7_vld_r;
      m2_vld_r <= m1_vld_r;
      m3_vld_r <= m2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    p7_r  <= dg_tag;
    g_r   <= dg_q[QV_W-1:0];
    m1_r  <= p7_r;
    pll_r <= PP_W'(p7_r.e2[AL_W-1:0]) * PP_W'(g_r[BL_W-1:0]);
    plh_r <= PP_W'(p7_r.e2[AL_W-1:0]) * PP_W'(g_r[QV_W-1:BL_W]);
    phl_r <= PP_W'(p7_r.e2[SQ_W-1:AL_W]) * PP_W'(g_r[BL_W-1:0]);
    phh_r <= PP_W'(p7_r.e2[SQ_W-1:AL_W]) * PP_W'(g_r[QV_W-1:BL_W]);
    m2_r  <= m1_r;
    x_r   <= PS_W'(pll_r) + (PS_W'(plh_r) << BL_W);
    y_r   <= PS_W'(phl_r) + (PS_W'(phh_r) << BL_W);
    m3_r  <= m2_r;
    p_r   <= PF_W'(x_r) + (PF_W'(y_r) << AL_W) + (PF_W'(1) << 31);
  end

  // Scale back by 2^32 with saturation.
  assign m_full = p_r[PF_W-1:32];
  assign m_cap  = (m_full > MF_W'(SLOPE_CAP)) ? SLOPE_CAP : m_full[SLOPE_W-1:0];

  // Result word: special cases override the computed values.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= m3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (m3_r.neg) begin
      out_index_r  <= DEFAULT_INDEX;
      out_slope_r  <= '0;
      out_status_r <= STAT_DEFAULT;
    end else if (m3_r.bad) begin
      out_index_r  <= '0;
      out_slope_r  <= '0;
      out_status_r <= STAT_ERROR;
    end else begin
      out_index_r  <= m3_r.idx;
      out_slope_r  <= SLOPE_W'(0) - m_cap;
      out_status_r <= STAT_OK;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_index       = out_index_r;
  assign out_index_slope = out_slope_r;
  assign out_status      = out_status_r;

endmodule

// File: sv/sri_div.sv
// Pipelined restoring divider: capped round(a * 2^SHIFT / b), one quotient bit per stage.
module sri_div #(
  parameter int          A_W   = sri_pkg::DIV_A_W,
  parameter int          SHIFT = sri_pkg::DIV_SHIFT,
  parameter int          B_W   = sri_pkg::DIV_B_W,
  parameter int          Q_W   = sri_pkg::DIV_Q_W,
  parameter logic [63:0] CAP   = sri_pkg::QUOT_CAP,
  parameter int          TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_vld,
  input  logic [A_W-1:0]   in_a,
  input  logic [B_W-1:0]   in_b,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_vld,
  output logic [Q_W:0]     out_q,
  output logic [TAG_W-1:0] out_tag
);

  localparam int N_W = A_W + SHIFT;
  localparam int H_W = N_W - Q_W;
  localparam int R_W = B_W + 1;
  localparam int C_W = (H_W > B_W) ? H_W : B_W;

  logic [N_W-1:0] num;
  logic [H_W-1:0] num_hi;
  logic           ovf;

  logic             vld_r [0:Q_W];
  logic             ovf_r [0:Q_W];
  logic [R_W-1:0]   rem_r [0:Q_W];
  logic [Q_W-1:0]   quo_r [0:Q_W];
  logic [Q_W-1:0]   low_r [0:Q_W];
  logic [B_W-1:0]   den_r [0:Q_W];
  logic [TAG_W-1:0] tag_r [0:Q_W];

  logic             out_vld_r;
  logic [Q_W:0]     out_q_r;
  logic [TAG_W-1:0] out_tag_r;

  logic [R_W:0]   rem_dbl;
  logic           round_up;
  logic [Q_W:0]   q_rnd;
  logic [Q_W:0]   cap_v;

  // Quotient overflow check: the high part of the dividend must stay below the divisor.
  assign num    = N_W'(in_a) << SHIFT;
  assign num_hi = num[N_W-1:Q_W];
  assign ovf    = C_W'(num_hi) >= C_W'(in_b);

  // Load stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    ovf_r[0] <= ovf;
    rem_r[0] <= ovf ? '0 : R_W'(num_hi);
    quo_r[0] <= '0;
    low_r[0] <= num[Q_W-1:0];
    den_r[0] <= in_b;
    tag_r[0] <= in_tag;
  end

  // One quotient bit per stage.
  for (genvar j = 1; j <= Q_W; j++) begin : g_step
    logic [R_W-1:0] shl;
    logic [R_W:0]   diff;
    logic           take;

    assign shl  = {rem_r[j-1][R_W-2:0], low_r[j-1][Q_W-j]};
    assign diff = {1'b0, shl} - {2'b00, den_r[j-1]};
    assign take = !diff[R_W];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else begin
        vld_r[j] <= vld_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      ovf_r[j] <= ovf_r[j-1];
      rem_r[j] <= take ? diff[R_W-1:0] : shl;
      quo_r[j] <= {quo_r[j-1][Q_W-2:0], take};
      low_r[j] <= low_r[j-1];
      den_r[j] <= den_r[j-1];
      tag_r[j] <= tag_r[j-1];
    end
  end

  // Round half up and apply the cap.
  assign rem_dbl  = {rem_r[Q_W], 1'b0};
  assign round_up = rem_dbl >= {2'b00, den_r[Q_W]};
  assign q_rnd    = {1'b0, quo_r[Q_W]} + (Q_W+1)'(round_up);
  assign cap_v    = CAP[Q_W:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= vld_r[Q_W];
    end
  end

  always_ff @(posedge clk) begin
    out_q_r   <= (ovf_r[Q_W] || (q_rnd > cap_v)) ? cap_v : q_rnd;
    out_tag_r <= tag_r[Q_W];
  end

  assign out_vld = out_vld_r;
  assign out_q   = out_q_r;
  assign out_tag = out_tag_r;

endmodule

// File: sv/sri_chk.sv
// Port-level checker for the Sellmeier index block and its bind.
`include "sellmeier_refractive_index_assert.svh"

module sri_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic [sri_pkg::IDX_W-1:0]         out_index,
  input logic signed [sri_pkg::SLOPE_W-1:0] out_index_slope,
  input logic [sri_pkg::STAT_W-1:0]        out_status
);

  import sri_pkg::*;

  // A computed word never has a positive slope.
  `SRI_ASSERT_NOW(a_slope_sign, out_valid && out_status == STAT_OK, out_index_slope[SLOPE_W-1] || out_index_slope == '0, "positive slope on a computed word")

  // The default case carries the fixed index and a flat slope.
  `SRI_ASSERT_NOW(a_default_word, out_valid && out_status == STAT_DEFAULT, out_index == DEFAULT_INDEX && out_index_slope == '0, "bad default word")

  // An error word carries zeros.
  `SRI_ASSERT_NOW(a_error_word, out_valid && out_status == STAT_ERROR, out_index == '0 && out_index_slope == '0, "error word not cleared")

  // Reset leaves no result in the cycle after it.
  `SRI_ASSERT_NEXT(a_reset_quiet, !rst_n, !out_valid, "result strobe right after reset")

endmodule

bind sellmeier_refractive_index sri_chk u_sri_chk (.*);
